>>> rtl/core/sec_pkg.sv
// Shared constants and types for the stereo echo comb core.
package sec_pkg;

   // History store depth in stereo frames and its address width
   localparam int MAX_DELAY = 32768;
   localparam int ADDR_W    = $clog2(MAX_DELAY);

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int FRAME_W  = 2 * SAMPLE_W;
   localparam int DELAY_W  = 15;
   localparam int GAIN_W   = 16;
   localparam int FRAC_W   = 15;

   // Product of a sample and a zero-extended gain
   localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
   // Channel sum with headroom for sample plus echo
   localparam int SUM_W  = SAMPLE_W + 2;

   // Unity gain in Q1.15
   localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1 << FRAC_W);
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1 << (FRAC_W - 1));

   // Bias that turns an arithmetic shift into truncation toward zero
   localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << FRAC_W) - 1);

   // Saturation limits
   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_DELAY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_GAIN  = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]   prod_type;

endpackage

>>> rtl/core/stereo_echo_comb_core.sv
// Stereo feedforward comb (echo) core: history memory, gain pipeline and output register.
// An accepted item passes stage 1, stage 2 and the output register before reaching rsp.
// Throughput: one item per cycle unless rsp stalls; each item takes one write and one
// read of history memory in the same cycle; each stage moves on when the next is free.
// Reset: clears the write pointer, the stored-frame count, all stage valids and sets
// echo_delay to 0 and echo_gain to 0.5; the history memory is not cleared and needs no
// clearing pass, since an entry is only read after it has been written.
module stereo_echo_comb_core
   import sec_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata,
   // input items
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sample_type           req_left_in,
   input  sample_type           req_right_in,
   // result items
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sample_type           rsp_left_out,
   output sample_type           rsp_right_out,
   output logic                 rsp_clipped
);

   // configuration registers
   logic [DELAY_W-1:0] delay_ff;
   logic [GAIN_W-1:0]  gain_ff;

   // stream state
   logic [ADDR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]  seen_ff, seen_in;

   // history memory
   logic [FRAME_W-1:0] hist_mem [MAX_DELAY];
   logic [FRAME_W-1:0] rd_data_ff;

   // stage 1: memory read returned
   logic               s1_valid_ff;
   sample_type         s1_left_ff, s1_right_ff;
   logic               s1_self_ff, s1_echo_ff;

   // stage 2: products registered
   logic               s2_valid_ff;
   sample_type         s2_left_ff, s2_right_ff;
   prod_type           s2_prod_l_ff, s2_prod_r_ff;

   // output register
   logic               rsp_valid_ff;
   sample_type         rsp_left_ff, rsp_right_ff;
   logic               rsp_clip_ff;

   // handshake and control
   logic               out_ready, s2_ready, s1_ready, req_fire;
   logic [ADDR_W-1:0]  delay_eff, seen_clamped, rd_addr;
   logic               zero_delay, echo_on;
   logic [GAIN_W-1:0]  gain_eff;
   sample_type         src_l, src_r;
   prod_type           prod_l, prod_r;
   sample_type         mix_l, mix_r;
   logic               clip_l, clip_r;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
         gain_ff  <= GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ECHO_DELAY: delay_ff <= csr_wdata[DELAY_W-1:0];
            CSR_ECHO_GAIN:  gain_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage readiness: a stage loads when it is empty or its successor loads
   always_comb begin
      out_ready = !rsp_valid_ff || !rsp_stall;
      s2_ready  = !s2_valid_ff || out_ready;
      s1_ready  = !s1_valid_ff || s2_ready;
      req_stall = !s1_ready;
      req_fire  = req_valid && s1_ready;
   end

   // Effective delay, clamped count and echo read address
   always_comb begin
      if (32'(delay_ff) >= 32'(MAX_DELAY)) begin
         delay_eff = ADDR_W'(MAX_DELAY - 1);
      end else begin
         delay_eff = ADDR_W'(delay_ff);
      end
      seen_clamped = (seen_ff > delay_eff) ? delay_eff : seen_ff;
      zero_delay   = (delay_eff == '0);
      echo_on      = !zero_delay && (seen_clamped == delay_eff);
      if (wr_ptr_ff >= delay_eff) begin
         rd_addr = wr_ptr_ff - delay_eff;
      end else begin
         rd_addr = ADDR_W'({1'b0, wr_ptr_ff} + (ADDR_W+1)'(MAX_DELAY) - {1'b0, delay_eff});
      end
      if (32'(wr_ptr_ff) + 32'd1 == 32'(MAX_DELAY)) begin
         wr_ptr_in = '0;
      end else begin
         wr_ptr_in = wr_ptr_ff + ADDR_W'(1);
      end
      seen_in = (seen_clamped < delay_eff) ? seen_clamped + ADDR_W'(1) : seen_clamped;
   end

   // Advance the write pointer and the stored-frame count per item
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         seen_ff   <= '0;
      end else if (req_fire) begin
         wr_ptr_ff <= wr_ptr_in;
         seen_ff   <= seen_in;
      end
   end

   // History memory: store the new frame, fetch the delayed one
   always_ff @(posedge clock) begin
      if (req_fire) begin
         hist_mem[wr_ptr_ff] <= {req_right_in, req_left_in};
         rd_data_ff          <= hist_mem[rd_addr];
      end
   end

   // Stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_left_ff  <= req_left_in;
         s1_right_ff <= req_right_in;
         s1_self_ff  <= zero_delay;
         s1_echo_ff  <= echo_on;
      end
   end

   // Pick the echo source and multiply by the clamped gain
   always_comb begin
      gain_eff = (gain_ff > GAIN_ONE) ? GAIN_ONE : gain_ff;
      if (s1_self_ff) begin
         src_l = s1_left_ff;
         src_r = s1_right_ff;
      end else if (s1_echo_ff) begin
         src_l = rd_data_ff[SAMPLE_W-1:0];
         src_r = rd_data_ff[FRAME_W-1:SAMPLE_W];
      end else begin
         src_l = '0;
         src_r = '0;
      end
      prod_l = PROD_W'(src_l) * PROD_W'($signed({1'b0, gain_eff}));
      prod_r = PROD_W'(src_r) * PROD_W'($signed({1'b0, gain_eff}));
   end

   // Stage 2 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_left_ff   <= s1_left_ff;
         s2_right_ff  <= s1_right_ff;
         s2_prod_l_ff <= prod_l;
         s2_prod_r_ff <= prod_r;
      end
   end

   // Scale, add and saturate each channel
   sec_scale_sat u_mix_left (
      .sample_i (s2_left_ff),
      .prod_i   (s2_prod_l_ff),
      .result_o (mix_l),
      .clip_o   (clip_l)
   );

   sec_scale_sat u_mix_right (
      .sample_i (s2_right_ff),
      .prod_i   (s2_prod_r_ff),
      .result_o (mix_r),
      .clip_o   (clip_r)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s2_valid_ff) begin
         rsp_left_ff  <= mix_l;
         rsp_right_ff <= mix_r;
         rsp_clip_ff  <= clip_l || clip_r;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;
   assign rsp_clipped   = rsp_clip_ff;

`ifndef SYNTHESIS
   // An echo read never targets the entry being written in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !zero_delay) |-> (rd_addr != wr_ptr_ff))
      else $error("echo read collides with history write");

   // An accepted item lands in stage 1
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted item lost before stage 1");

   // The write pointer moves on by exactly one frame per item
   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (wr_ptr_ff == $past(wr_ptr_in)) && (wr_ptr_ff != $past(wr_ptr_ff)))
      else $error("write pointer did not advance");

   // A clip flag comes with at least one channel at a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_clip_ff) |->
         (rsp_left_ff == SAT_MAX || rsp_left_ff == SAT_MIN ||
          rsp_right_ff == SAT_MAX || rsp_right_ff == SAT_MIN))
      else $error("clip flag without a saturated channel");

   // The echo is only enabled once the count has reached the delay
   a_echo_after_fill: assert property (@(posedge clock) disable iff (reset)
      (req_fire && echo_on) |-> (seen_clamped == delay_eff) && (delay_eff != '0))
      else $error("echo enabled before history filled");
`endif

endmodule

>>> rtl/core/sec_scale_sat.sv
// One channel of the mix: scale the echo product, add the dry sample, saturate.
module sec_scale_sat
   import sec_pkg::*;
(
   input  sample_type sample_i,
   input  prod_type   prod_i,
   output sample_type result_o,
   output logic       clip_o
);

   logic signed [PROD_W-1:0]   biased;
   logic signed [PROD_W-1:0]   scaled;
   logic signed [SAMPLE_W:0]   echo;
   logic signed [SUM_W-1:0]    sum;

   // Drop the fraction, truncating toward zero
   always_comb begin
      biased = prod_i + (prod_i[PROD_W-1] ? $signed(ROUND_BIAS) : $signed(PROD_W'(0)));
      scaled = biased >>> FRAC_W;
      echo   = scaled[SAMPLE_W:0];
   end

   // Add the dry sample and clamp to the sample range
   always_comb begin
      sum = SUM_W'(sample_i) + SUM_W'(echo);
      if (sum > SUM_W'(SAT_MAX)) begin
         result_o = SAT_MAX;
         clip_o   = 1'b1;
      end else if (sum < SUM_W'(SAT_MIN)) begin
         result_o = SAT_MIN;
         clip_o   = 1'b1;
      end else begin
         result_o = sum[SAMPLE_W-1:0];
         clip_o   = 1'b0;
      end
   end

endmodule

>>> test/tb_stereo_echo_comb_core.sv
// Self-checking testbench for the stereo echo comb core with its own echo predictor.
module tb_stereo_echo_comb_core
   import sec_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 7;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct {
      sample_type left;
      sample_type right;
   } stereo_frame_type;

   typedef struct {
      sample_type left;
      sample_type right;
      logic       clip;
   } echo_frame_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ECHO_DELAY;
   logic [GAIN_W-1:0]    csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   sample_type           req_left_in = '0;
   sample_type           req_right_in = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   sample_type           rsp_left_out;
   sample_type           rsp_right_out;
   logic                 rsp_clipped;

   // Echo predictor state and its copy of the registers
   logic [FRAME_W-1:0] frame_history [MAX_DELAY];
   int                 hist_wr_ptr = 0;
   int                 hist_count = 0;
   int                 cfg_delay = 0;
   int                 cfg_gain = int'(GAIN_RESET);

   // Frames waiting to be sent and echoed frames waiting to come back
   stereo_frame_type frame_backlog [$];
   echo_frame_type   echo_due [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int send_gap = 0;
   int stall_left = 0;
   int frames_sent = 0;
   int frames_checked = 0;
   int clipped_seen = 0;
   int settings_used = 0;
   int error_count = 0;
   int cycle_count = 0;

   stereo_frame_type next_frame;
   echo_frame_type   due_frame;

   stereo_echo_comb_core dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .rsp_clipped   (rsp_clipped)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample times Q1.15 gain, truncated toward zero
   function automatic int scale_by_gain(input sample_type s, input int g);
      int p;
      p = int'(s) * g;
      if (p >= 0) return p >>> 15;
      return -((-p) >>> 15);
   endfunction

   // Work out the echoed frame for one accepted frame and advance the history
   function automatic void predict_echo(input sample_type l, input sample_type r);
      int             d;
      int             g;
      int             el;
      int             er;
      int             sl;
      int             sr;
      int             rd;
      logic [FRAME_W-1:0] old;
      echo_frame_type e;
      d = cfg_delay;
      g = (cfg_gain > int'(GAIN_ONE)) ? int'(GAIN_ONE) : cfg_gain;
      if (d >= MAX_DELAY) d = MAX_DELAY - 1;
      // a shorter delay pulls the stored-frame count down with it
      if (hist_count > d) hist_count = d;
      el = 0;
      er = 0;
      if (d == 0) begin
         el = scale_by_gain(l, g);
         er = scale_by_gain(r, g);
      end else if (hist_count >= d) begin
         rd = (hist_wr_ptr >= d) ? hist_wr_ptr - d : hist_wr_ptr + MAX_DELAY - d;
         old = frame_history[rd];
         el = scale_by_gain(sample_type'(old[SAMPLE_W-1:0]), g);
         er = scale_by_gain(sample_type'(old[FRAME_W-1:SAMPLE_W]), g);
      end
      frame_history[hist_wr_ptr] = {r, l};
      hist_wr_ptr = (hist_wr_ptr + 1) % MAX_DELAY;
      if (hist_count < d) hist_count++;
      // saturate each channel and flag the clip
      sl = int'(l) + el;
      sr = int'(r) + er;
      e.clip = 1'b0;
      if (sl > 32767) begin
         sl = 32767;
         e.clip = 1'b1;
      end else if (sl < -32768) begin
         sl = -32768;
         e.clip = 1'b1;
      end
      if (sr > 32767) begin
         sr = 32767;
         e.clip = 1'b1;
      end else if (sr < -32768) begin
         sr = -32768;
         e.clip = 1'b1;
      end
      e.left = sample_type'(sl);
      e.right = sample_type'(sr);
      echo_due.push_back(e);
   endfunction

   // Drive frames from the backlog, holding each until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_echo(req_left_in, req_right_in);
            frames_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (frame_backlog.size() > 0) begin
               next_frame = frame_backlog.pop_front();
               req_left_in <= next_frame.left;
               req_right_in <= next_frame.right;
               req_valid <= 1'b1;
               if ($urandom_range(99) < send_idle_pct) send_gap = $urandom_range(1, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check each result against the oldest due frame, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (echo_due.size() == 0) begin
               $display("%0t: result with nothing due: left %0d right %0d clipped %0b",
                        $time, rsp_left_out, rsp_right_out, rsp_clipped);
               error_count++;
            end else begin
               due_frame = echo_due.pop_front();
               frames_checked++;
               if (rsp_left_out !== due_frame.left) begin
                  $display("%0t: left_out expected %0d, got %0d",
                           $time, due_frame.left, rsp_left_out);
                  error_count++;
               end
               if (rsp_right_out !== due_frame.right) begin
                  $display("%0t: right_out expected %0d, got %0d",
                           $time, due_frame.right, rsp_right_out);
                  error_count++;
               end
               if (rsp_clipped !== due_frame.clip) begin
                  $display("%0t: clipped expected %0b, got %0b",
                           $time, due_frame.clip, rsp_clipped);
                  error_count++;
               end
               if (due_frame.clip) clipped_seen++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(99) < recv_idle_pct) begin
            stall_left = $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results still due", $time, echo_due.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Write one register and mirror it in the predictor
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ECHO_DELAY) cfg_delay = int'(val[DELAY_W-1:0]);
      else cfg_gain = int'(val);
   endtask

   task automatic push_frame(input int l, input int r);
      stereo_frame_type f;
      f.left = sample_type'(l);
      f.right = sample_type'(r);
      frame_backlog.push_back(f);
   endtask

   // Hold until every frame is sent and every result is back, then let the pipe empty
   task automatic settle();
      do @(negedge clock);
      while (frame_backlog.size() != 0 || req_valid || echo_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int rand_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return 32767;
      if (pick < 16) return -32768;
      if (pick < 30) return $urandom_range(0, 128) - 64;
      return int'(sample_type'($urandom));
   endfunction

   function automatic int rand_idle_pct();
      case ($urandom_range(2))
         0: return 0;
         1: return 15;
         default: return 40;
      endcase
   endfunction

   task automatic run_random_frames(input int n, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      settings_used++;
      repeat (n) push_frame(rand_sample(), rand_sample());
      settle();
   endtask

   initial begin
      int                pick;
      int                dly;
      logic [GAIN_W-1:0] wd;
      logic [GAIN_W-1:0] gain;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 20;
      recv_idle_pct = 20;

      // Zero delay at unity gain: each frame doubles, clipping at both rails
      write_csr(CSR_ECHO_GAIN, GAIN_ONE);
      write_csr(CSR_ECHO_DELAY, '0);
      push_frame(32767, -32768);
      push_frame(0, 0);
      push_frame(1, -1);
      push_frame(16383, -16384);
      push_frame(16384, 0);
      settle();

      // Gain above one acts as one
      write_csr(CSR_ECHO_GAIN, 16'hFFFF);
      push_frame(16384, -16385);
      push_frame(100, -100);
      settle();

      // Zero gain leaves the frame untouched
      write_csr(CSR_ECHO_GAIN, '0);
      push_frame(32767, -32768);
      push_frame(-1, 1);
      settle();

      // Half gain, short delay: no echo until the delay has filled
      write_csr(CSR_ECHO_GAIN, GAIN_RESET);
      write_csr(CSR_ECHO_DELAY, 16'd3);
      push_frame(32767, -32768);
      push_frame(-1, 1);
      push_frame(100, 200);
      push_frame(32767, -32768);
      push_frame(1, -1);
      push_frame(-3, 5);
      settle();

      // Shorten the delay mid-stream; the negative echo must truncate toward zero
      write_csr(CSR_ECHO_DELAY, 16'd1);
      push_frame(7, -7);
      push_frame(-32768, 32767);
      settle();

      // Lengthen it: the count carries on, so the echo stays off for a while
      write_csr(CSR_ECHO_DELAY, 16'd5);
      push_frame(1000, -1000);
      push_frame(-5, 5);
      push_frame(32767, -32768);
      settle();

      // Longest delay, with the spare top data bit set
      write_csr(CSR_ECHO_DELAY, 16'hFFFF);
      push_frame(12345, -12345);
      push_frame(-32768, 32767);
      settle();

      // Random settings, each phase drained before the next write
      repeat (10) begin
         pick = $urandom_range(99);
         if (pick < 25) dly = 0;
         else if (pick < 75) dly = $urandom_range(1, 40);
         else if (pick < 90) dly = $urandom_range(41, 600);
         else dly = $urandom_range(601, 32767);
         pick = $urandom_range(99);
         if (pick < 20) gain = GAIN_ONE;
         else if (pick < 30) gain = '0;
         else if (pick < 40) gain = GAIN_W'($urandom_range(32769, 65535));
         else gain = GAIN_W'($urandom_range(0, 32768));
         wd = GAIN_W'(dly);
         wd[GAIN_W-1] = 1'($urandom_range(1));
         if ($urandom_range(3) != 0) write_csr(CSR_ECHO_DELAY, wd);
         if ($urandom_range(3) != 0) write_csr(CSR_ECHO_GAIN, gain);
         run_random_frames($urandom_range(100, 140), rand_idle_pct(), rand_idle_pct());
      end

      // Closing stretch at full rate with no idling on either side
      write_csr(CSR_ECHO_DELAY, DELAY_W'($urandom_range(1, 24)));
      write_csr(CSR_ECHO_GAIN, GAIN_W'($urandom_range(0, 65535)));
      run_random_frames(60, 0, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (echo_due.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, echo_due.size());
         error_count++;
      end
      $display("Sent %0d stereo frames under %0d random and 7 directed settings;",
               frames_sent, settings_used);
      $display("checked %0d echoed frames, %0d of them clipped, %0d mismatches.",
               frames_checked, clipped_seen, error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
